FILE: rtl/isqrt_pkg.sv
// Shared constant for the integer square root pipeline.
`default_nettype none

package isqrt_pkg;

   // Each pipeline step brings down this many radicand bits and settles one root bit.
   localparam int unsigned BITS_PER_STEP = 2;

endpackage : isqrt_pkg

`default_nettype wire

FILE: rtl/isqrt_stage.sv
// One digit-by-digit square root step with its own pipeline register and handshake.
`default_nettype none

module isqrt_stage
   import isqrt_pkg::*;
#(
   parameter int unsigned ROOT_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 up_valid,
   output logic                                      up_ready,
   input  wire logic [ROOT_BITS:0]                   up_rem,
   input  wire logic [ROOT_BITS-1:0]                 up_root,
   input  wire logic [BITS_PER_STEP*ROOT_BITS-1:0]   up_rad,
   output logic                                      dn_valid,
   input  wire logic                                 dn_ready,
   output logic [ROOT_BITS:0]                        dn_rem,
   output logic [ROOT_BITS-1:0]                      dn_root,
   output logic [BITS_PER_STEP*ROOT_BITS-1:0]        dn_rad
);

   localparam int unsigned RAD_BITS = BITS_PER_STEP * ROOT_BITS;
   localparam int unsigned ACC_BITS = ROOT_BITS + BITS_PER_STEP;

   logic                   vld_ff;
   logic                   vld_in;
   logic [ROOT_BITS:0]     rem_ff;
   logic [ROOT_BITS:0]     rem_in;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [ROOT_BITS-1:0]   root_in;
   logic [RAD_BITS-1:0]    rad_ff;
   logic [RAD_BITS-1:0]    rad_in;
   logic [ACC_BITS-1:0]    acc;
   logic [ACC_BITS-1:0]    trial;
   logic [ACC_BITS-1:0]    diff;
   logic [ROOT_BITS:0]     root_shift;
   logic                   fits;

   // The incoming remainder never exceeds twice the partial root, so its top bit is zero here.
   always_comb begin
      acc        = {up_rem[ROOT_BITS-1:0], up_rad[RAD_BITS-1 -: BITS_PER_STEP]};
      trial      = {up_root, {(BITS_PER_STEP-1){1'b0}}, 1'b1};
      diff       = acc - trial;
      fits       = (acc >= trial);
      root_shift = {up_root, fits};
      root_in    = root_shift[ROOT_BITS-1:0];
      rem_in     = fits ? diff[ROOT_BITS:0] : acc[ROOT_BITS:0];
      rad_in     = up_rad << BITS_PER_STEP;
      up_ready   = !vld_ff || dn_ready;
      vld_in     = up_ready ? up_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_rad   = rad_ff;

endmodule : isqrt_stage

`default_nettype wire

FILE: rtl/integer_square_root_floor_unit.sv
// Top level of the pipelined floor integer square root unit.
//
//   Channel | Direction | Payload                          | Handshake
//   --------+-----------+----------------------------------+--------------------
//   req     | in        | req_radicand, RADICAND_BITS bits | req_valid/req_ready
//   rsp     | out       | rsp_root, ceil(RADICAND_BITS/2)  | rsp_valid/rsp_ready
//
// The root is settled by a chain of ROOT_BITS identical stages, one root bit per stage
// (16 stages for the default 31-bit radicand), each a single narrow subtract and compare.
// A new transfer can be taken on every cycle while the output is not stalled. A request
// passes through the stage registers in order, and rsp_valid rises once it is held in the
// last one.
// Reset is synchronous and active high; it clears the stage valid bits and the checking
// count, while the datapath registers are left as they are.
// Each stage holds its item while the stage after it is full and not ready, so a stall
// at the output lets empty stages behind it fill up before req_ready falls.
`default_nettype none

module integer_square_root_floor_unit
   import isqrt_pkg::*;
#(
   parameter int unsigned RADICAND_BITS = 31
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [RADICAND_BITS-1:0]              req_radicand,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [(RADICAND_BITS+1)/2-1:0]             rsp_root
);

   localparam int unsigned ROOT_BITS = (RADICAND_BITS + 1) / 2;
   localparam int unsigned RAD_BITS  = BITS_PER_STEP * ROOT_BITS;
   localparam int unsigned CNT_BITS  = $clog2(ROOT_BITS + 1);

   // Stage i reads index i of each chain and drives index i+1.
   logic [ROOT_BITS:0]     valid_chain;
   logic [ROOT_BITS:0]     ready_chain;
   logic [ROOT_BITS:0]     rem_chain  [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]   root_chain [ROOT_BITS+1];
   logic [RAD_BITS-1:0]    rad_chain  [ROOT_BITS+1];

   // The radicand is zero-extended to an even width so every step takes a full bit pair.
   assign valid_chain[0] = req_valid;
   assign req_ready      = ready_chain[0];
   assign rem_chain[0]   = '0;
   assign root_chain[0]  = '0;
   assign rad_chain[0]   = RAD_BITS'(req_radicand);

   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
      isqrt_stage #(
         .ROOT_BITS (ROOT_BITS)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_chain[i]),
         .up_ready (ready_chain[i]),
         .up_rem   (rem_chain[i]),
         .up_root  (root_chain[i]),
         .up_rad   (rad_chain[i]),
         .dn_valid (valid_chain[i+1]),
         .dn_ready (ready_chain[i+1]),
         .dn_rem   (rem_chain[i+1]),
         .dn_root  (root_chain[i+1]),
         .dn_rad   (rad_chain[i+1])
      );
   end

   // The last stage register doubles as the output register.
   assign ready_chain[ROOT_BITS] = rsp_ready;
   assign rsp_valid              = valid_chain[ROOT_BITS];
   assign rsp_root               = root_chain[ROOT_BITS];

   // Count of items between request and response transfers, kept for checking only.
   logic [CNT_BITS-1:0] occupancy_ff;
   logic [CNT_BITS-1:0] occupancy_in;

   always_comb begin
      occupancy_in = occupancy_ff + CNT_BITS'(req_valid && req_ready)
                                  - CNT_BITS'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
      end else begin
         occupancy_ff <= occupancy_in;
      end
   end

   // Every accepted item sits in exactly one stage until its response transfer.
   a_occupancy_matches : assert property (@(posedge clock) disable iff (reset)
      int'(occupancy_ff) == $countones(valid_chain[ROOT_BITS:1]))
      else $error("pipeline valid bits disagree with transfer count");

   // Requests are refused only when every stage holds an item.
   a_no_wasted_stall : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_chain[ROOT_BITS:1]))
      else $error("request stalled while a stage is empty");

   // Nothing leaves the pipeline in the cycle after a reset cycle.
   a_reset_empties : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule : integer_square_root_floor_unit

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the floor integer square root unit.
`timescale 1ns / 100ps

module tb;

   // Block geometry at its default size.
   localparam int RADICAND_BITS  = 31;
   localparam int ROOT_BITS      = (RADICAND_BITS + 1) / 2;
   localparam int TOP_QUAD_SHIFT = (RADICAND_BITS - 1) & ~1;
   localparam int MAX_ROOT       = 46340;

   // Stimulus sizing and idling. Every third window of 128 transfers runs with no
   // idling on either side, so the pipeline also sees back-to-back traffic.
   localparam int RANDOM_ITEMS   = 1900;
   localparam int MAX_IDLE       = 4;
   localparam int QUIET_WINDOW   = 128;
   localparam int DRAIN_POINT    = 1000;

   typedef struct {
      logic [RADICAND_BITS-1:0] radicand;
      logic [ROOT_BITS-1:0]     root;
   } root_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid    = 1'b0;
   logic                     req_ready;
   logic [RADICAND_BITS-1:0] req_radicand = '0;
   logic                     rsp_valid;
   logic                     rsp_ready    = 1'b0;
   logic [ROOT_BITS-1:0]     rsp_root;

   // Radicands still to be sent, each with a flag that holds it back until the
   // block has delivered every result it owes.
   logic [RADICAND_BITS-1:0] radicand_pending_q[$];
   bit                       drain_before_q[$];

   // Roots the block owes us, oldest first.
   root_entry_type root_expected_q[$];

   int error_count    = 0;
   int requests_sent  = 0;
   int roots_checked  = 0;
   int squares_sent   = 0;
   int drains_done    = 0;

   integer_square_root_floor_unit #(
      .RADICAND_BITS(RADICAND_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_radicand(req_radicand),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_root    (rsp_root)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Digit-by-digit restoring square root. Each step tries to set the next root bit
   // by subtracting the trial value; the partial root is kept pre-shifted so that
   // it lines up with the current bit weight.
   function automatic logic [ROOT_BITS-1:0] floor_root_of(input logic [RADICAND_BITS-1:0] x);
      logic [RADICAND_BITS:0] remainder;
      logic [RADICAND_BITS:0] partial;
      logic [RADICAND_BITS:0] weight;
      logic [RADICAND_BITS:0] trial;
      remainder = {1'b0, x};
      partial   = '0;
      weight    = '0;
      weight[TOP_QUAD_SHIFT] = 1'b1;
      for (int step = 0; step < ROOT_BITS; step++) begin
         trial = partial + weight;
         if (remainder >= trial) begin
            remainder = remainder - trial;
            partial   = (partial >> 1) + weight;
         end else begin
            partial = partial >> 1;
         end
         weight = weight >> 2;
      end
      return partial[ROOT_BITS-1:0];
   endfunction

   // Random radicand, weighted toward the edges of each root step: exact squares,
   // one below a square, and the largest value that still has the same root.
   function automatic logic [RADICAND_BITS-1:0] random_radicand();
      logic [RADICAND_BITS-1:0] value;
      logic [63:0]              wide;
      int unsigned              base;
      int unsigned              width;
      base = $urandom_range(MAX_ROOT, 1);
      case ($urandom_range(5, 0))
         0: begin
            value = RADICAND_BITS'($urandom);
         end
         1: begin
            wide  = 64'(base) * 64'(base);
            value = wide[RADICAND_BITS-1:0];
         end
         2: begin
            wide  = 64'(base) * 64'(base) - 64'd1;
            value = wide[RADICAND_BITS-1:0];
         end
         3: begin
            wide = 64'(base) * 64'(base) + 64'(2 * base);
            if (wide >= (64'd1 << RADICAND_BITS)) begin
               value = '1;
            end else begin
               value = wide[RADICAND_BITS-1:0];
            end
         end
         4: begin
            width = $urandom_range(RADICAND_BITS, 1);
            value = RADICAND_BITS'($urandom) & RADICAND_BITS'((64'd1 << width) - 64'd1);
         end
         default: begin
            value = RADICAND_BITS'($urandom_range(1000, 0));
         end
      endcase
      return value;
   endfunction

   // Stimulus list. The directed part covers zero and one, the smallest non-trivial
   // values, powers of two, alternating bit patterns, the largest exact square that
   // fits and the full-scale radicand. A drain is requested at the start of the
   // random part and again partway through it.
   initial begin
      logic [RADICAND_BITS-1:0] directed[$];
      directed = '{
         31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd8, 31'd9, 31'd15, 31'd16,
         31'd255, 31'd256, 31'd65535, 31'd65536, 31'h4000_0000, 31'h3FFF_FFFF,
         31'h5555_5555, 31'h2AAA_AAAA, 31'd2147395599, 31'd2147395600,
         31'h7FFF_FFFE, 31'h7FFF_FFFF
      };
      foreach (directed[i]) begin
         radicand_pending_q.push_back(directed[i]);
         drain_before_q.push_back(1'b0);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         radicand_pending_q.push_back(random_radicand());
         drain_before_q.push_back(i == 0 || i == DRAIN_POINT);
      end
   end

   // Request driver. An item goes out once its idle gap has run down; a flagged item
   // also waits until the block has nothing outstanding. The next valid state is
   // worked out first so that valid gets a single assignment per edge.
   int unsigned req_gap_left = 0;

   always @(posedge clock) begin
      logic                     next_valid;
      logic [RADICAND_BITS-1:0] next_radicand;
      root_entry_type           owed;
      next_valid    = req_valid;
      next_radicand = req_radicand;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            owed.radicand = req_radicand;
            owed.root     = floor_root_of(req_radicand);
            root_expected_q.push_back(owed);
            requests_sent++;
            if (64'(owed.root) * 64'(owed.root) == 64'(req_radicand)) begin
               squares_sent++;
            end
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
            end else if (radicand_pending_q.size() > 0 &&
                         !(drain_before_q[0] && root_expected_q.size() > 0)) begin
               if (drain_before_q[0]) begin
                  drains_done++;
               end
               next_valid    = 1'b1;
               next_radicand = radicand_pending_q.pop_front();
               void'(drain_before_q.pop_front());
               if ((requests_sent / QUIET_WINDOW) % 3 == 2) begin
                  req_gap_left = 0;
               end else begin
                  req_gap_left = $urandom_range(MAX_IDLE, 0);
               end
            end
         end
      end
      req_valid    <= next_valid;
      req_radicand <= next_radicand;
   end

   // Result monitor. Every transfer is checked against the oldest owed root, and a
   // fresh stall is drawn for the receiver after each one.
   int unsigned rsp_stall_left = 0;

   always @(posedge clock) begin
      root_entry_type owed;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (root_expected_q.size() == 0) begin
               $display("%0t: unexpected root %0d with no request outstanding",
                        $time, rsp_root);
               error_count++;
            end else begin
               owed = root_expected_q.pop_front();
               roots_checked++;
               if (rsp_root !== owed.root) begin
                  $display("%0t: root mismatch for radicand %0d: expected %0d, actual %0d",
                           $time, owed.radicand, owed.root, rsp_root);
                  error_count++;
               end
            end
            if ((roots_checked / QUIET_WINDOW) % 3 == 2) begin
               rsp_stall_left = 0;
            end else begin
               rsp_stall_left = $urandom_range(MAX_IDLE, 0);
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Reset, then wait for every request to go out and every root to come back.
   // The extra cycles at the end let any stray result from the pipeline show up.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (radicand_pending_q.size() > 0 || req_valid) begin
         @(posedge clock);
      end
      while (root_expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (4 * ROOT_BITS) @(posedge clock);
      $display("Sent %0d radicands (%0d exact squares) and checked %0d roots;",
               requests_sent, squares_sent, roots_checked);
      $display("the request side drained the pipeline %0d times along the way.",
               drains_done);
      if (error_count == 0 && root_expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run of this stimulus.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: sim.f
rtl/isqrt_pkg.sv
rtl/isqrt_stage.sv
rtl/integer_square_root_floor_unit.sv
test/tb.sv
